// File: rtl/hba_pkg.sv
package hba_pkg;

   localparam int NUM_BINS   = 4096;
   localparam int ADDR_BITS  = $clog2(NUM_BINS);
   localparam int COUNT_BITS = 24;
   localparam int VAL_BITS   = 17;
   localparam int LIM_BITS   = ADDR_BITS + 1;
   localparam int DIV_STEPS  = VAL_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LIM_BITS-1:0]   NUM_BINS_L = LIM_BITS'(NUM_BINS);

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OOB = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   localparam logic [1:0] CSR_BINS_PER_ROW = 2'd0;
   localparam logic [1:0] CSR_ROW_SCALE    = 2'd1;
   localparam logic [1:0] CSR_BINS_IN_USE  = 2'd2;

   typedef struct packed {
      logic [1:0]          mode;
      logic [VAL_BITS-1:0] x_value;
      logic [VAL_BITS-1:0] y_value;
      logic [11:0]         read_index;
      logic                last_point;
   } hba_req_type;

   typedef struct packed {
      logic [11:0]           bin_index;
      logic [COUNT_BITS-1:0] bin_count;
      logic [VAL_BITS-1:0]   mean_x;
      logic [VAL_BITS-1:0]   mean_y;
      logic [1:0]            status;
      logic                  last_out;
   } hba_rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [VAL_BITS-1:0]   mx;
      logic [VAL_BITS-1:0]   my;
   } hba_entry_type;

   typedef struct packed {
      logic load_in;
      logic mul_en;
      logic sq1_en;
      logic sq2_en;
      logic sel_en;
      logic idx_en;
      logic mem_rd;
      logic cur_load;
      logic div_init;
      logic div_step;
      logic wb;
      logic clr_init;
      logic clr_wr;
      logic clr_all;
      logic out_load;
   } hba_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       oob;
      logic       sat;
      logic       div_done;
      logic       clr_done;
   } hba_stat_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DISP, S_MUL, S_SQ1, S_SQ2, S_SEL, S_IDX,
      S_CHK, S_RDW, S_DINIT, S_DIV, S_WB, S_CLR, S_OUT
   } hba_state_type;

endpackage

// File: rtl/hba_ctrl.sv
module hba_ctrl
   import hba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  hba_stat_type stat,
   output hba_cmd_type  cmd
);

   hba_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_all = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
            else cmd.clr_wr = 1'b1;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.mode)
               MODE_ADD:   state_in = S_MUL;
               MODE_READ:  state_in = S_CHK;
               MODE_CLEAR: begin
                  cmd.clr_init = 1'b1;
                  state_in     = S_CLR;
               end
               default:    state_in = S_OUT;
            endcase
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_SQ1;
         end
         S_SQ1: begin
            cmd.sq1_en = 1'b1;
            state_in   = S_SQ2;
         end
         S_SQ2: begin
            cmd.sq2_en = 1'b1;
            state_in   = S_SEL;
         end
         S_SEL: begin
            cmd.sel_en = 1'b1;
            state_in   = S_IDX;
         end
         S_IDX: begin
            cmd.idx_en = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (stat.oob) state_in = S_OUT;
            else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_RDW;
            end
         end
         S_RDW: begin
            cmd.cur_load = 1'b1;
            state_in     = (stat.mode == MODE_ADD) ? S_DINIT : S_OUT;
         end
         S_DINIT: begin
            if (stat.sat) state_in = S_OUT;
            else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_WB;
         end
         S_WB: begin
            cmd.wb   = 1'b1;
            state_in = S_OUT;
         end
         S_CLR: begin
            if (stat.clr_done) state_in = S_OUT;
            else cmd.clr_wr = 1'b1;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

endmodule

// File: rtl/hba_dp.sv
module hba_dp
   import hba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hba_req_type  req_data,
   output hba_rsp_type  rsp_data,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_write_data,
   input  hba_cmd_type  cmd,
   output hba_stat_type stat
);

   logic [6:0]          bpr_ff;
   logic [23:0]         rs_ff;
   logic [12:0]         biu_ff;
   hba_req_type         req_ff;
   logic [23:0]         sx_ff;
   logic [24:0]         sy_ff;
   logic [30:0]         sqx1_ff, sqy1_ff, sqx2_ff, sqy2_ff;
   logic [9:0]          isel_ff;
   logic [8:0]          jsel_ff;
   logic                rnd_ff;
   logic [18:0]         m_ff;
   hba_entry_type       mem [NUM_BINS];
   hba_entry_type       rd_ff, cur_ff;
   logic                sat_ff;
   logic [COUNT_BITS-1:0] dvs_ff;
   logic [COUNT_BITS-1:0] remx_ff, remy_ff;
   logic [VAL_BITS-1:0] qx_ff, qy_ff;
   logic                negx_ff, negy_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [LIM_BITS-1:0] clr_ptr_ff;
   hba_rsp_type         rsp_ff, rsp_in;

   logic [LIM_BITS-1:0] limit, clr_target;
   logic [6:0]          c1;
   logic [40:0]         prod_y;
   logic signed [16:0]  dx1, dy1;
   logic signed [15:0]  dx2, dy2;
   logic signed [33:0]  px1, py1;
   logic signed [31:0]  px2, py2;
   logic [32:0]         d1, d2;
   logic [34:0]         d1x3;
   logic                use_rnd;
   logic [9:0]          i1;
   logic [8:0]          j1;
   logic [17:0]         ipart;
   logic [18:0]         m_in;
   logic                oob;
   logic [ADDR_BITS-1:0] raddr;
   logic signed [17:0]  diffx, diffy;
   logic [17:0]         magx, magy;
   logic [COUNT_BITS:0] tx, ty;
   logic                gex, gey;
   logic [VAL_BITS-1:0] newx, newy;
   hba_entry_type       wdata;
   logic                we;
   logic [ADDR_BITS-1:0] waddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpr_ff <= 7'd30;
         rs_ff  <= 24'd1097283;
         biu_ff <= 13'd4096;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BINS_PER_ROW: bpr_ff <= csr_write_data[6:0];
            CSR_ROW_SCALE:    rs_ff  <= csr_write_data;
            CSR_BINS_IN_USE:  biu_ff <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   assign limit      = (biu_ff > NUM_BINS_L) ? NUM_BINS_L : biu_ff;
   assign clr_target = cmd.clr_all ? NUM_BINS_L : limit;

   assign c1     = (bpr_ff == 7'd0) ? 7'd0 : bpr_ff - 7'd1;
   assign prod_y = 41'(rs_ff) * 41'(req_ff.y_value);

   assign dx1 = $signed({sx_ff[15], sx_ff[15:0]});
   assign dy1 = $signed({sy_ff[15], sy_ff[15:0]});
   assign dx2 = $signed({~sx_ff[15], sx_ff[14:0]});
   assign dy2 = $signed({~sy_ff[15], sy_ff[14:0]});
   assign px1 = 34'(dx1) * 34'(dx1);
   assign py1 = 34'(dy1) * 34'(dy1);
   assign px2 = 32'(dx2) * 32'(dx2);
   assign py2 = 32'(dy2) * 32'(dy2);

   assign d1   = {2'b0, sqx1_ff} + {1'b0, sqy1_ff, 1'b0} + {2'b0, sqy1_ff};
   assign d2   = {2'b0, sqx2_ff} + {1'b0, sqy2_ff, 1'b0} + {2'b0, sqy2_ff};
   assign d1x3 = {2'b0, d1} + {1'b0, d1, 1'b0};
   assign use_rnd = (d1 < 33'h0_4000_0000) ? 1'b1 :
                    (d1x3 > 35'h1_0000_0000) ? 1'b0 : (d1 <= d2);
   assign i1 = {1'b0, sy_ff[24:16]} + {9'd0, sy_ff[15]};
   assign j1 = {1'b0, sx_ff[23:16]} + {8'd0, sx_ff[15]};

   assign ipart = 18'(isel_ff) * 18'({bpr_ff, 1'b0});
   assign m_in  = {1'b0, ipart} + {10'd0, jsel_ff} +
                  (rnd_ff ? 19'd0 : {12'd0, bpr_ff});

   assign oob = (req_ff.mode == MODE_ADD) ? (m_ff >= {6'd0, limit})
                                          : ({1'b0, req_ff.read_index} >= limit);
   assign raddr = (req_ff.mode == MODE_ADD) ? m_ff[ADDR_BITS-1:0]
                                            : req_ff.read_index;

   assign diffx = $signed({1'b0, req_ff.x_value}) - $signed({1'b0, cur_ff.mx});
   assign diffy = $signed({1'b0, req_ff.y_value}) - $signed({1'b0, cur_ff.my});
   assign magx  = diffx[17] ? 18'(-diffx) : 18'(diffx);
   assign magy  = diffy[17] ? 18'(-diffy) : 18'(diffy);

   assign tx  = {remx_ff, qx_ff[VAL_BITS-1]};
   assign ty  = {remy_ff, qy_ff[VAL_BITS-1]};
   assign gex = (tx >= {1'b0, dvs_ff});
   assign gey = (ty >= {1'b0, dvs_ff});

   assign newx = negx_ff ? cur_ff.mx - qx_ff : cur_ff.mx + qx_ff;
   assign newy = negy_ff ? cur_ff.my - qy_ff : cur_ff.my + qy_ff;

   always_comb begin
      we    = cmd.wb || cmd.clr_wr;
      waddr = cmd.wb ? m_ff[ADDR_BITS-1:0] : clr_ptr_ff[ADDR_BITS-1:0];
      wdata = '0;
      if (cmd.wb) begin
         wdata.count = cur_ff.count + 1'b1;
         wdata.mx    = newx;
         wdata.my    = newy;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.mem_rd) rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         step_ff    <= '0;
      end else begin
         if (cmd.clr_init) clr_ptr_ff <= '0;
         else if (cmd.clr_wr) clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (cmd.div_init) step_ff <= '0;
         else if (cmd.div_step) step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) req_ff <= req_data;
      if (cmd.mul_en) begin
         sx_ff <= 24'(c1) * 24'(req_ff.x_value);
         sy_ff <= prod_y[40:16];
      end
      if (cmd.sq1_en) begin
         sqx1_ff <= px1[30:0];
         sqy1_ff <= py1[30:0];
      end
      if (cmd.sq2_en) begin
         sqx2_ff <= px2[30:0];
         sqy2_ff <= py2[30:0];
      end
      if (cmd.sel_en) begin
         rnd_ff  <= use_rnd;
         isel_ff <= use_rnd ? i1 : {1'b0, sy_ff[24:16]};
         jsel_ff <= use_rnd ? j1 : {1'b0, sx_ff[23:16]};
      end
      if (cmd.idx_en) m_ff <= m_in;
      if (cmd.cur_load) begin
         cur_ff <= rd_ff;
         sat_ff <= (rd_ff.count == COUNT_MAX);
      end else if (cmd.wb) begin
         cur_ff <= wdata;
      end
      if (cmd.div_init) begin
         dvs_ff  <= cur_ff.count + 1'b1;
         remx_ff <= '0;
         remy_ff <= '0;
         qx_ff   <= magx[VAL_BITS-1:0];
         qy_ff   <= magy[VAL_BITS-1:0];
         negx_ff <= diffx[17];
         negy_ff <= diffy[17];
      end else if (cmd.div_step) begin
         remx_ff <= gex ? COUNT_BITS'(tx - {1'b0, dvs_ff}) : tx[COUNT_BITS-1:0];
         remy_ff <= gey ? COUNT_BITS'(ty - {1'b0, dvs_ff}) : ty[COUNT_BITS-1:0];
         qx_ff   <= {qx_ff[VAL_BITS-2:0], gex};
         qy_ff   <= {qy_ff[VAL_BITS-2:0], gey};
      end
      if (cmd.out_load) rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_in          = '0;
      rsp_in.last_out = req_ff.last_point;
      case (req_ff.mode)
         MODE_ADD: begin
            if (oob) rsp_in.status = ST_OOB;
            else begin
               rsp_in.bin_index = m_ff[11:0];
               rsp_in.bin_count = cur_ff.count;
               rsp_in.mean_x    = cur_ff.mx;
               rsp_in.mean_y    = cur_ff.my;
               rsp_in.status    = sat_ff ? ST_SAT : ST_OK;
            end
         end
         MODE_READ: begin
            rsp_in.bin_index = req_ff.read_index;
            if (oob) rsp_in.status = ST_OOB;
            else begin
               rsp_in.bin_count = cur_ff.count;
               rsp_in.mean_x    = cur_ff.mx;
               rsp_in.mean_y    = cur_ff.my;
            end
         end
         default: ;
      endcase
   end

   assign rsp_data      = rsp_ff;
   assign stat.mode     = req_ff.mode;
   assign stat.oob      = oob;
   assign stat.sat      = sat_ff;
   assign stat.div_done = (step_ff == STEP_BITS'(DIV_STEPS - 1));
   assign stat.clr_done = (clr_ptr_ff >= clr_target);

endmodule

// File: rtl/hexagonal_bin_accumulator_top.sv
// Hexagonal bin accumulator.
// Request channel: req_valid/req_stall with req_data; a request is taken
// when req_valid is high and req_stall low. Response channel: rsp_valid/
// rsp_stall with rsp_data, one response per request, in order.
// csr_write_enable/csr_index/csr_write_data write bins_per_row (0),
// row_scale (1) and bins_in_use (2); write only while idle.
// An add point is scaled, squared, snapped to a bin, checked, read,
// divided (both means in the bit-per-cycle divider) and written back.
// An add out of range ends at the check, one into a saturated bin skips
// the divide; a read is checked and read; a clear writes each bin below
// the limit, one bin written per cycle on the single write port; a
// no-op only answers. One request is in work at a time; a new request
// is taken the cycle after the response is loaded. The response sits
// in an output register; while rsp_stall is high the next request is
// still taken and worked, and its response waits for the register to
// free. Reset is synchronous. After reset all 4096 bins are zeroed
// with req_stall high; CSR writes are taken meanwhile.
module hexagonal_bin_accumulator_top
   import hba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hba_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hba_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   hba_cmd_type  cmd;
   hba_stat_type stat;

   hba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   hba_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

// File: tb/sv/hba_checker.sv
module hba_checker
   import hba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  hba_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  hba_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
   logic [VAL_BITS-1:0]   mx_mem  [NUM_BINS];
   logic [VAL_BITS-1:0]   my_mem  [NUM_BINS];
   logic [6:0]            bins_per_row;
   logic [23:0]           row_scale;
   logic [12:0]           bins_in_use;
   hba_rsp_type           expected_rsp_q [$];

   assign pending = expected_rsp_q.size();

   function automatic longint unsigned hex_dist(longint sx, longint sy,
                                                longint cx, longint cy);
      longint dx, dy;
      dx = sx - cx;
      dy = sy - cy;
      return longint'(dx * dx) + 3 * longint'(dy * dy);
   endfunction

   function automatic logic [VAL_BITS-1:0] mean_step(logic [VAL_BITS-1:0] mean,
                                                     logic [VAL_BITS-1:0] v,
                                                     logic [COUNT_BITS-1:0] c);
      longint diff, q;
      diff = longint'(v) - longint'(mean);
      q = diff / longint'(c);
      return VAL_BITS'(longint'(mean) + q);
   endfunction

   function automatic hba_rsp_type bin_update(hba_req_type r);
      hba_rsp_type o;
      longint unsigned lim, c1, sx, sy, i1, j1, i2, j2, d1, d2, m, st;
      logic use_round;
      o = '0;
      o.last_out = r.last_point;
      lim = (bins_in_use < NUM_BINS) ? bins_in_use : NUM_BINS;
      case (r.mode)
         MODE_ADD: begin
            c1 = (bins_per_row > 0) ? bins_per_row - 1 : 0;
            sx = c1 * r.x_value;
            sy = (longint'(row_scale) * r.y_value) >> 16;
            i1 = (sy + 32768) >> 16;
            j1 = (sx + 32768) >> 16;
            i2 = sy >> 16;
            j2 = sx >> 16;
            st = bins_per_row;
            d1 = hex_dist(sx, sy, j1 << 16, i1 << 16);
            if (d1 < (64'd1 << 30)) use_round = 1;
            else if (3 * d1 > (64'd1 << 32)) use_round = 0;
            else begin
               d2 = hex_dist(sx, sy, (j2 << 16) + 32768, (i2 << 16) + 32768);
               use_round = d1 <= d2;
            end
            m = use_round ? i1 * 2 * st + j1 : i2 * 2 * st + j2 + st;
            if (m >= lim) o.status = ST_OOB;
            else begin
               o.bin_index = m[11:0];
               if (cnt_mem[m] == COUNT_MAX) o.status = ST_SAT;
               else begin
                  cnt_mem[m] = cnt_mem[m] + 1;
                  mx_mem[m] = mean_step(mx_mem[m], r.x_value, cnt_mem[m]);
                  my_mem[m] = mean_step(my_mem[m], r.y_value, cnt_mem[m]);
               end
               o.bin_count = cnt_mem[m];
               o.mean_x = mx_mem[m];
               o.mean_y = my_mem[m];
            end
         end
         MODE_READ: begin
            o.bin_index = r.read_index;
            if (r.read_index >= lim) o.status = ST_OOB;
            else begin
               o.bin_count = cnt_mem[r.read_index];
               o.mean_x = mx_mem[r.read_index];
               o.mean_y = my_mem[r.read_index];
            end
         end
         MODE_CLEAR: begin
            for (int k = 0; k < lim; k++) begin
               cnt_mem[k] = '0;
               mx_mem[k] = '0;
               my_mem[k] = '0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      hba_rsp_type e;
      if (reset) begin
         for (int k = 0; k < NUM_BINS; k++) begin
            cnt_mem[k] = '0;
            mx_mem[k] = '0;
            my_mem[k] = '0;
         end
         bins_per_row = 7'd30;
         row_scale = 24'd1097283;
         bins_in_use = 13'd4096;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BINS_PER_ROW: bins_per_row = csr_write_data[6:0];
               CSR_ROW_SCALE:    row_scale = csr_write_data;
               CSR_BINS_IN_USE:  bins_in_use = csr_write_data[12:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_rsp_q.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) expected_rsp_q.push_back(bin_update(req_data));
      end
   end

endmodule

// File: tb/sv/tb.sv
module tb;
   import hba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   hba_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   hba_rsp_type rsp_data;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_write_data = '0;
   int          fail_count, pending;
   int          send_idle_pct = 0, stall_pct = 0;
   bit          hold_off = 0;
   longint      cycle_count = 0;

   always #5 clock = ~clock;

   hexagonal_bin_accumulator_top dut (.*);

   hba_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_request(hba_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [23:0] v);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (4200) @(posedge clock);
   endtask

   function automatic hba_req_type rand_point;
      hba_req_type r;
      r.mode = MODE_ADD;
      r.x_value = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      r.y_value = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      r.read_index = 12'($urandom);
      r.last_point = $urandom_range(1);
      return r;
   endfunction

   function automatic hba_req_type rand_req;
      hba_req_type r;
      int pick;
      r = rand_point();
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.mode = MODE_READ;
         r.read_index = ($urandom_range(1)) ? 12'($urandom_range(300)) : 12'($urandom);
      end else if (pick < 17) r.mode = MODE_NOP;
      else if (pick < 18) r.mode = MODE_CLEAR;
      return r;
   endfunction

   task automatic mk(logic [1:0] m, logic [16:0] x, logic [16:0] y,
                     logic [11:0] ri, logic lp);
      hba_req_type r;
      r.mode = m;
      r.x_value = x;
      r.y_value = y;
      r.read_index = ri;
      r.last_point = lp;
      send_request(r);
   endtask

   initial begin
      int bpr_set [6] = '{30, 2, 64, 0, 1, 17};
      int rs_set  [6] = '{1097283, 37837, 2421893, 16777215, 0, 605000};
      int biu_set [6] = '{4096, 1, 8191, 4096, 200, 100};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      mk(MODE_ADD, 0, 0, 0, 0);
      mk(MODE_ADD, 65536, 65536, 0, 0);
      mk(MODE_ADD, 65536, 0, 0, 0);
      mk(MODE_ADD, 0, 65536, 0, 1);
      mk(MODE_ADD, 17'h1FFFF, 17'h1FFFF, 0, 0);
      mk(MODE_ADD, 32768, 32768, 0, 0);
      mk(MODE_ADD, 32768, 32768, 0, 0);
      mk(MODE_ADD, 1111, 30000, 0, 0);
      mk(MODE_READ, 0, 0, 0, 0);
      mk(MODE_READ, 17'h1FFFF, 17'h1FFFF, 12'hFFF, 1);
      mk(MODE_NOP, 17'h1FFFF, 17'h1FFFF, 12'hFFF, 1);
      mk(MODE_CLEAR, 0, 0, 0, 1);
      mk(MODE_READ, 0, 0, 0, 0);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_BINS_PER_ROW, 24'(bpr_set[ph]));
         csr_write(CSR_ROW_SCALE, 24'(rs_set[ph]));
         csr_write(CSR_BINS_IN_USE, 24'(biu_set[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         if (ph == 2) fork
            begin
               hold_off = 1;
               repeat (300) @(posedge clock);
               hold_off = 0;
            end
         join_none
         for (int n = 0; n < 180; n++) send_request(rand_req());
         drain();
      end
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
